// ===== hw/rtl/fpsm_pkg.sv =====
package fpsm_pkg;

	localparam int QUOT_W = 32;
	localparam int TICK_W = 32;
	localparam int PPL_W  = 10;
	localparam int MINP_W = 16;
	localparam int DEN_W  = TICK_W + PPL_W;
	localparam int CFG_W  = 32;

	localparam logic [39:0] RATE_SCALE = 40'd600_000_000_000;
	localparam logic [31:0] RATE_LO    = RATE_SCALE[31:0];
	localparam logic [31:0] RATE_HI    = {24'd0, RATE_SCALE[39:32]};
	localparam logic [31:0] VOL_SCALE  = 32'd10000;

	localparam logic [1:0] CFG_WINDOW  = 2'd0;
	localparam logic [1:0] CFG_MIN_PUL = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;
	localparam logic [1:0] CFG_PPL     = 2'd3;

	localparam logic [TICK_W-1:0] WINDOW_RST  = 32'd500000;
	localparam logic [MINP_W-1:0] MIN_PUL_RST = 16'd3;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd2000000;
	localparam logic [PPL_W-1:0]  PPL_RST     = 10'd66;

	typedef enum logic [2:0] {
		TK_NONE,
		TK_CLEAR,
		TK_FIRST,
		TK_STARTUP,
		TK_RUN
	} tick_op_t;

	typedef enum logic [2:0] {
		CO_NONE,
		CO_VOL_MUL,
		CO_RLO_MUL,
		CO_RHI_MUL,
		CO_NUM_ADD,
		CO_DEN_MUL
	} calc_op_t;

	typedef enum logic {
		DIV_VOL,
		DIV_RATE
	} div_sel_t;

	typedef struct packed {
		tick_op_t tick_op;
		calc_op_t calc_op;
		logic     div_start;
		div_sel_t div_sel;
		logic     save_vol;
		logic     load_few;
		logic     load_done;
	} fpsm_cmd_t;

	typedef struct packed {
		logic window_end;
		logic too_few;
		logic timeout;
		logic div_busy;
		logic out_full;
	} fpsm_status_t;

endpackage

// ===== hw/rtl/fpsm_div.sv =====
module fpsm_div
	import fpsm_pkg::*;
#(
	parameter int NUM_W = 56,
	parameter int DIV_W = 42
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIV_W-1:0]  den,
	output logic              busy,
	output logic [QUOT_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  rem_q;
	logic [QUOT_W-1:0] q_q;
	logic              over_q;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] rem_sub;
	logic           ge;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// One quotient bit per cycle. Quotient bits above bit 31 only raise the
	// overflow flag, which saturates the result.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			q_q   <= {q_q[QUOT_W-2:0], ge};
			if (ge && cnt_q > CNT_W'(QUOT_W)) begin
				over_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign quot = over_q ? '1 : q_q;

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == CNT_W'(NUM_W)))
		else $error("divider did not start a full run");

	a_quot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !start) |=> $stable(quot))
		else $error("quotient changed while divider idle");

endmodule

// ===== hw/rtl/fpsm_dp.sv =====
module fpsm_dp
	import fpsm_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               pulse,
	input  fpsm_cmd_t          cmd,
	output fpsm_status_t       status,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic               res_status,
	output logic [TICK_W-1:0]  res_duration,
	output logic [15:0]        res_total,
	output logic [QUOT_W-1:0]  res_rate,
	output logic [QUOT_W-1:0]  res_volume
);

	localparam int CW = COUNT_WIDTH;
	localparam int NW = COUNT_WIDTH + 40;

	logic [TICK_W-1:0] window_q;
	logic [MINP_W-1:0] min_pul_q;
	logic [TICK_W-1:0] timeout_q;
	logic [PPL_W-1:0]  ppl_q;

	logic [CW-1:0]     count_q;
	logic [TICK_W-1:0] ticks_q;
	logic [TICK_W-1:0] idle_q;

	logic [CW-1:0]     count_n;
	logic [TICK_W-1:0] ticks_n;
	logic [TICK_W-1:0] idle_n;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       p_q;
	logic [63:0]       lo_q;
	logic [NW-1:0]     num_q;
	logic [QUOT_W-1:0] vol_q;

	logic [NW-1:0]     div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_busy;
	logic [QUOT_W-1:0] quot;

	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RST;
			min_pul_q <= MIN_PUL_RST;
			timeout_q <= TIMEOUT_RST;
			ppl_q     <= PPL_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WINDOW:  window_q  <= cfg_wdata[TICK_W-1:0];
				CFG_MIN_PUL: min_pul_q <= cfg_wdata[MINP_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_wdata[TICK_W-1:0];
				CFG_PPL:     ppl_q     <= cfg_wdata[PPL_W-1:0];
				default: ;
			endcase
		end
	end

	assign ticks_n = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
	assign count_n = (pulse && count_q != '1) ? count_q + 1'b1 : count_q;
	assign idle_n  = pulse ? '0 : ((idle_q == '1) ? idle_q : idle_q + 1'b1);

	assign status.window_end = ticks_n >= window_q;
	assign status.too_few    = 32'(count_n) < 32'(min_pul_q);
	assign status.timeout    = idle_n >= timeout_q;
	assign status.div_busy   = div_busy;
	assign status.out_full   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ticks_q <= '0;
			idle_q  <= '0;
		end else begin
			case (cmd.tick_op)
				TK_CLEAR: begin
					count_q <= '0;
					ticks_q <= '0;
					idle_q  <= '0;
				end
				TK_FIRST: begin
					count_q <= CW'(1);
					ticks_q <= '0;
					idle_q  <= '0;
				end
				TK_STARTUP: begin
					count_q <= count_n;
					ticks_q <= ticks_n;
					idle_q  <= '0;
				end
				TK_RUN: begin
					count_q <= count_n;
					ticks_q <= ticks_n;
					idle_q  <= idle_n;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_a = 32'(count_q);
		mul_b = VOL_SCALE;
		case (cmd.calc_op)
			CO_RLO_MUL: mul_b = RATE_LO;
			CO_RHI_MUL: mul_b = RATE_HI;
			CO_DEN_MUL: begin
				mul_a = ticks_q;
				mul_b = 32'(ppl_q);
			end
			default: ;
		endcase
	end

	// The rate numerator is count * scale, built from a low and a high
	// partial product because the scale is wider than 32 bits.
	always_ff @(posedge clk) begin
		case (cmd.calc_op)
			CO_VOL_MUL, CO_RLO_MUL, CO_DEN_MUL: p_q <= mul_a * mul_b;
			CO_RHI_MUL: begin
				p_q  <= mul_a * mul_b;
				lo_q <= p_q;
			end
			CO_NUM_ADD: num_q <= NW'(lo_q) + {p_q[NW-33:0], 32'd0};
			default: ;
		endcase
		if (cmd.save_vol) begin
			vol_q <= quot;
		end
	end

	always_comb begin
		if (cmd.div_sel == DIV_RATE) begin
			div_num = num_q;
			div_den = p_q[DEN_W-1:0];
		end else begin
			div_num = NW'(p_q);
			div_den = DEN_W'(ppl_q);
		end
	end

	fpsm_div #(
		.NUM_W(NW),
		.DIV_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_few || cmd.load_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_few) begin
			res_status   <= 1'b1;
			res_duration <= ticks_n;
			res_total    <= 16'(count_n);
			res_rate     <= '0;
			res_volume   <= '0;
		end else if (cmd.load_done) begin
			res_status   <= 1'b0;
			res_duration <= ticks_q;
			res_total    <= 16'(count_q);
			res_rate     <= quot;
			res_volume   <= vol_q;
		end
	end

	assign m_tvalid = out_valid_q;

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_few |=> (res_status && res_rate == '0 && res_volume == '0))
		else $error("too-few result carries rate or volume");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick_op == TK_RUN && !pulse) |=> $stable(count_q))
		else $error("pulse count moved on a tick without pulse");

endmodule

// ===== hw/rtl/fpsm_ctrl.sv =====
module fpsm_ctrl
	import fpsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         start_cmd,
	input  logic         pulse,
	input  logic         m_tready,
	input  fpsm_status_t status,
	output fpsm_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ARMED,
		S_STARTUP,
		S_RUNNING,
		S_VMUL,
		S_VGO,
		S_VWAIT,
		S_RLO,
		S_RHI,
		S_ADD,
		S_DEN,
		S_RGO,
		S_RWAIT,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   tick_state;
	logic   slot_free;
	logic   acc;

	assign tick_state = (state_q == S_IDLE) || (state_q == S_ARMED) ||
	                    (state_q == S_STARTUP) || (state_q == S_RUNNING);
	assign slot_free  = !status.out_full || m_tready;
	assign s_tready   = tick_state && slot_free;
	assign acc        = s_tvalid && s_tready;

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		cmd.tick_op   = TK_NONE;
		cmd.calc_op   = CO_NONE;
		cmd.div_sel   = DIV_VOL;
		if (acc && start_cmd) begin
			cmd.tick_op = TK_CLEAR;
			state_n     = S_ARMED;
		end else begin
			case (state_q)
				S_IDLE: ;
				S_ARMED: begin
					if (acc && pulse) begin
						cmd.tick_op = TK_FIRST;
						state_n     = S_STARTUP;
					end
				end
				S_STARTUP: begin
					if (acc) begin
						cmd.tick_op = TK_STARTUP;
						if (status.window_end) begin
							if (status.too_few) begin
								cmd.load_few = 1'b1;
								state_n      = S_IDLE;
							end else begin
								state_n = S_RUNNING;
							end
						end
					end
				end
				S_RUNNING: begin
					if (acc) begin
						cmd.tick_op = TK_RUN;
						if (status.timeout) begin
							state_n = S_VMUL;
						end
					end
				end
				S_VMUL: begin
					cmd.calc_op = CO_VOL_MUL;
					state_n     = S_VGO;
				end
				S_VGO: begin
					cmd.div_start = 1'b1;
					state_n       = S_VWAIT;
				end
				S_VWAIT: begin
					if (!status.div_busy) begin
						cmd.save_vol = 1'b1;
						state_n      = S_RLO;
					end
				end
				S_RLO: begin
					cmd.calc_op = CO_RLO_MUL;
					state_n     = S_RHI;
				end
				S_RHI: begin
					cmd.calc_op = CO_RHI_MUL;
					state_n     = S_ADD;
				end
				S_ADD: begin
					cmd.calc_op = CO_NUM_ADD;
					state_n     = S_DEN;
				end
				S_DEN: begin
					cmd.calc_op = CO_DEN_MUL;
					state_n     = S_RGO;
				end
				S_RGO: begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_RATE;
					state_n       = S_RWAIT;
				end
				S_RWAIT: begin
					cmd.div_sel = DIV_RATE;
					if (!status.div_busy) begin
						state_n = S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						cmd.load_done = 1'b1;
						state_n       = S_IDLE;
					end
				end
				default: state_n = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_busy |-> !s_tready)
		else $error("input accepted while division runs");

endmodule

// ===== hw/rtl/flow_pulse_session_meter.sv =====
// Throughput: one tick per cycle while armed or counting and no result awaits m_tready.
// A too-few-pulses result is registered on the edge of the tick that ends the window.
// A completed session computes its volume and then its rate by running the one-bit-per-cycle
// divider twice; no tick is taken meanwhile.
// Reset (arst_n low) clears the session to idle and loads the register defaults.
module flow_pulse_session_meter
	import fpsm_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [0] pulse
	input  logic             s_tuser,  // [0] cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [111:0]     m_tdata,  // [31:0] duration_ticks, [47:32] pulse_total,
	                                   // [79:48] rate_ml_per_min, [111:80] volume_ml
	output logic             m_tuser   // [0] status
);

	fpsm_cmd_t    cmd;
	fpsm_status_t status;

	logic [TICK_W-1:0] res_duration;
	logic [15:0]       res_total;
	logic [QUOT_W-1:0] res_rate;
	logic [QUOT_W-1:0] res_volume;

	fpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.start_cmd(s_tuser),
		.pulse    (s_tdata[0]),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fpsm_dp #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.pulse       (s_tdata[0]),
		.cmd         (cmd),
		.status      (status),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.res_status  (m_tuser),
		.res_duration(res_duration),
		.res_total   (res_total),
		.res_rate    (res_rate),
		.res_volume  (res_volume)
	);

	assign m_tdata = {res_volume, res_rate, res_total, res_duration};

endmodule
